// ===== rtl/core/b64c_pkg.sv =====
// Shared types, constants and character mapping functions for the base64 codec.
package b64c_pkg;

    localparam logic [7:0] PAD_CHAR  = 8'h3d;
    localparam logic [5:0] SIX_BITS  = 6'h3f;
    localparam logic [5:0] VAL_PLUS  = 6'h3e;
    localparam logic [7:0] CHAR_UC_A = 8'h41;

    localparam int unsigned ADDR_W = 3;

    localparam logic REG_CODEC_MODE = 1'b0;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } req_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       message_end;
    } rsp_beat_t;

    // One group's worth of results; byte_arr[0] goes out first.
    typedef struct packed {
        logic [3:0][7:0] byte_arr;
        logic [2:0]      count;
        logic            last;
    } job_t;

    function automatic logic [7:0] char_of(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
        begin
            c = CHAR_UC_A + {2'b00, v};
        end
        else if (v < 6'd52)
        begin
            c = 8'h61 + {2'b00, v - 6'd26};
        end
        else if (v < 6'd62)
        begin
            c = 8'h30 + {2'b00, v - 6'd52};
        end
        else if (v == VAL_PLUS)
        begin
            c = 8'h2b;
        end
        else
        begin
            c = 8'h2f;
        end
        return c;
    endfunction

    function automatic logic [5:0] value_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= CHAR_UC_A && c <= 8'h5a)
        begin
            d = c - CHAR_UC_A;
        end
        else if (c >= 8'h61 && c <= 8'h7a)
        begin
            d = c - 8'h61 + 8'd26;
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30 + 8'd52;
        end
        else if (c == 8'h2b)
        begin
            d = {2'b00, VAL_PLUS};
        end
        else if (c == 8'h2f || c == 8'h5c)
        begin
            d = {2'b00, SIX_BITS};
        end
        return d[5:0];
    endfunction

endpackage

// ===== rtl/core/base64_codec_core.sv =====
// Top level of the streaming base64 codec: config register, front end, queue, back end.
//
// Usage:
//   req channel (req_valid/req_stall/req_data) takes one byte per beat, with
//   last_byte marking the end of a message. rsp channel (rsp_valid/rsp_stall/
//   rsp_data) returns result bytes; run_last flags the final byte produced by
//   one input beat, message_end flags bytes caused by the message's last beat.
//   codec_mode at address 0 selects encode (0) or decode (1); writing it clears
//   any partial group. Write it only while the codec is idle.
// Timing:
//   An input beat is accepted while req_stall is low; a job it completes goes
//   into the queue and then into the back end's job register, which offers its
//   first result beat. The back end sends one byte per cycle while rsp_stall is
//   low, so three encode input beats give four output bytes; decoding then sustains
//   one input beat per cycle. A two-entry job queue decouples the sides:
//   req_stall rises only when both queue entries are occupied.
// Reset:
//   rst_n clears the mode to encode, the group state, the queue and the output.
// Stall:
//   While rsp_stall is high the current beat holds; the queue absorbs up to
//   two further groups before req_stall is raised.
module base64_codec_core
    import b64c_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              req_valid,
    output logic              req_stall,
    input  req_beat_t         req_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rsp_beat_t         rsp_data
);

    logic mode_reg, mode_next;
    logic cfg_wr;
    logic push, q_full, pop, q_not_empty;
    job_t push_job, q_job;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CODEC_MODE);
    assign prdata = (paddr[2] == REG_CODEC_MODE) ? {31'b0, mode_reg} : 32'b0;

    always_comb
    begin
        mode_next = cfg_wr ? pwdata[0] : mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ENCODE;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    b64c_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .cfg_clear (cfg_wr),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    b64c_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_job   (q_job)
    );

    b64c_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_job       (q_job),
        .pop         (pop),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data)
    );

endmodule

// ===== rtl/core/b64c_front.sv =====
// Front end: accepts beats, gathers groups and posts finished groups as jobs.
module b64c_front
    import b64c_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      mode,
    input  logic      cfg_clear,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_beat_t req_data,
    input  logic      q_full,
    output logic      push,
    output job_t      push_job
);

    logic [23:0] group_bits_reg, group_bits_next;
    logic [1:0]  group_count_reg, group_count_next;
    logic [2:0]  pad_run_reg, pad_run_next;
    logic        stopped_reg, stopped_next;

    logic        take;
    logic [1:0]  cnt;
    logic [2:0]  cnt1;
    logic [23:0] merged;
    logic [2:0]  pad_cur;
    logic        padded;
    job_t        job;

    assign req_stall = q_full;
    assign take      = req_valid && !q_full;

    always_comb
    begin
        group_bits_next  = group_bits_reg;
        group_count_next = group_count_reg;
        pad_run_next     = pad_run_reg;
        stopped_next     = stopped_reg;
        job.byte_arr     = '0;
        job.count        = 3'd0;
        job.last         = req_data.last_byte;
        cnt              = 2'd0;
        cnt1             = 3'd0;
        merged           = group_bits_reg;
        pad_cur          = 3'd0;
        padded           = 1'b0;

        if (take)
        begin
            if (mode == MODE_ENCODE)
            begin
                cnt = (group_count_reg == 2'd3) ? 2'd0 : group_count_reg;
                unique case (cnt)
                    2'd0:    merged = group_bits_reg | {req_data.data_byte, 16'h0000};
                    2'd1:    merged = group_bits_reg | {8'h00, req_data.data_byte, 8'h00};
                    default: merged = group_bits_reg | {16'h0000, req_data.data_byte};
                endcase
                cnt1 = {1'b0, cnt} + 3'd1;
                if (cnt1 == 3'd3 || req_data.last_byte)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        if (3'(k) <= cnt1)
                        begin
                            job.byte_arr[k] = char_of(merged[23 - 6 * k -: 6]);
                        end
                        else
                        begin
                            job.byte_arr[k] = PAD_CHAR;
                        end
                    end
                    job.count        = 3'd4;
                    group_bits_next  = '0;
                    group_count_next = 2'd0;
                    pad_run_next     = 3'd0;
                    stopped_next     = 1'b0;
                end
                else
                begin
                    group_bits_next  = merged;
                    group_count_next = cnt1[1:0];
                end
            end
            else if (!stopped_reg)
            begin
                unique case (group_count_reg)
                    2'd0:    merged = group_bits_reg
                                      | {value_of(req_data.data_byte), 18'h00000};
                    2'd1:    merged = group_bits_reg
                                      | {6'h00, value_of(req_data.data_byte), 12'h000};
                    2'd2:    merged = group_bits_reg
                                      | {12'h000, value_of(req_data.data_byte), 6'h00};
                    default: merged = group_bits_reg
                                      | {18'h00000, value_of(req_data.data_byte)};
                endcase
                padded  = (req_data.data_byte == PAD_CHAR);
                pad_cur = padded ? pad_run_reg + 3'd1 : 3'd0;
                if (group_count_reg == 2'd3)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        job.byte_arr[k] = merged[23 - 8 * k -: 8];
                    end
                    if (!padded)
                    begin
                        job.count = 3'd3;
                    end
                    else if (pad_cur >= 3'd3)
                    begin
                        job.count = 3'd0;
                    end
                    else
                    begin
                        job.count = 3'd3 - pad_cur;
                    end
                    group_bits_next  = '0;
                    group_count_next = 2'd0;
                    pad_run_next     = 3'd0;
                    stopped_next     = padded;
                end
                else
                begin
                    group_bits_next  = merged;
                    group_count_next = group_count_reg + 2'd1;
                    pad_run_next     = pad_cur;
                end
            end

            if (req_data.last_byte)
            begin
                group_bits_next  = '0;
                group_count_next = 2'd0;
                pad_run_next     = 3'd0;
                stopped_next     = 1'b0;
            end
        end

        if (cfg_clear)
        begin
            group_bits_next  = '0;
            group_count_next = 2'd0;
            pad_run_next     = 3'd0;
            stopped_next     = 1'b0;
        end
    end

    assign push     = take && (job.count != 3'd0);
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_bits_reg  <= '0;
            group_count_reg <= 2'd0;
            pad_run_reg     <= 3'd0;
            stopped_reg     <= 1'b0;
        end
        else
        begin
            group_bits_reg  <= group_bits_next;
            group_count_reg <= group_count_next;
            pad_run_reg     <= pad_run_next;
            stopped_reg     <= stopped_next;
        end
    end

endmodule

// ===== rtl/core/b64c_queue.sv =====
// Two-entry job queue between the front and back ends.
module b64c_queue
    import b64c_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t pop_job
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push, do_pop;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign pop_job   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/core/b64c_back.sv =====
// Back end: takes jobs from the queue and sends their bytes one beat at a time.
module b64c_back
    import b64c_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_not_empty,
    input  job_t      q_job,
    output logic      pop,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_beat_t rsp_data
);

    job_t       job_reg, job_next;
    logic [1:0] idx_reg, idx_next;
    logic       busy_reg, busy_next;
    logic       fire;
    logic       final_beat;

    assign final_beat = ({1'b0, idx_reg} == job_reg.count - 3'd1);
    assign fire       = busy_reg && !rsp_stall;
    assign pop        = q_not_empty && (!busy_reg || (fire && final_beat));

    assign rsp_valid            = busy_reg;
    assign rsp_data.out_byte    = job_reg.byte_arr[idx_reg];
    assign rsp_data.run_last    = final_beat;
    assign rsp_data.message_end = job_reg.last;

    always_comb
    begin
        job_next  = job_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (pop)
        begin
            job_next  = q_job;
            idx_next  = 2'd0;
            busy_next = 1'b1;
        end
        else if (fire)
        begin
            if (final_beat)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 2'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule

// ===== bench/tb_base64_codec_core.sv =====
// Self-checking bench for base64_codec_core: directed table, random messages, APB writes.
module tb_base64_codec_core;
    timeunit 1ns;
    timeprecision 1ps;
    import b64c_pkg::*;

    typedef struct packed {
        logic        mode;
        logic [7:0]  chr;
        logic        fin;
        logic        typed;
        logic [2:0]  typed_n;
        logic [31:0] typed_out;
    } plan_row_t;

    // typed_out holds the typed result bytes, first byte in the top bits
    localparam plan_row_t [0:24] PLAN = {
        {MODE_ENCODE, 8'h4d,    1'b1, 1'b1, 3'd4, "TQ=="},
        {MODE_ENCODE, 8'h00,    1'b0, 1'b0, 3'd0, 32'd0},
        {MODE_ENCODE, 8'hff,    1'b0, 1'b0, 3'd0, 32'd0},
        {MODE_ENCODE, 8'h80,    1'b0, 1'b1, 3'd4, "AP+A"},
        {MODE_ENCODE, 8'hff,    1'b0, 1'b0, 3'd0, 32'd0},
        {MODE_ENCODE, 8'hff,    1'b1, 1'b1, 3'd4, "//8="},
        // padded group, then input ignored until the message ends
        {MODE_DECODE, "T",      1'b0, 1'b0, 3'd0, 32'd0},
        {MODE_DECODE, "Q",      1'b0, 1'b0, 3'd0, 32'd0},
        {MODE_DECODE, PAD_CHAR, 1'b0, 1'b0, 3'd0, 32'd0},
        {MODE_DECODE, PAD_CHAR, 1'b0, 1'b1, 3'd1, {"M", 24'd0}},
        {MODE_DECODE, "Z",      1'b1, 1'b1, 3'd0, 32'd0},
        // backslash and an unknown character
        {MODE_DECODE, "\\",     1'b0, 1'b0, 3'd0, 32'd0},
        {MODE_DECODE, "-",      1'b0, 1'b0, 3'd0, 32'd0},
        {MODE_DECODE, "/",      1'b0, 1'b0, 3'd0, 32'd0},
        {MODE_DECODE, PAD_CHAR, 1'b1, 1'b0, 3'd0, 32'd0},
        // three pads yield nothing
        {MODE_DECODE, "a",      1'b0, 1'b0, 3'd0, 32'd0},
        {MODE_DECODE, PAD_CHAR, 1'b0, 1'b0, 3'd0, 32'd0},
        {MODE_DECODE, PAD_CHAR, 1'b0, 1'b0, 3'd0, 32'd0},
        {MODE_DECODE, PAD_CHAR, 1'b1, 1'b1, 3'd0, 32'd0},
        // pad in first place decodes as zero
        {MODE_DECODE, PAD_CHAR, 1'b0, 1'b0, 3'd0, 32'd0},
        {MODE_DECODE, "A",      1'b0, 1'b0, 3'd0, 32'd0},
        {MODE_DECODE, "B",      1'b0, 1'b0, 3'd0, 32'd0},
        {MODE_DECODE, "+",      1'b0, 1'b0, 3'd0, 32'd0},
        // incomplete trailing group is dropped
        {MODE_DECODE, "Q",      1'b0, 1'b0, 3'd0, 32'd0},
        {MODE_DECODE, "U",      1'b1, 1'b1, 3'd0, 32'd0}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              req_valid = 1'b0;
    logic              req_stall;
    req_beat_t         req_data = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    rsp_beat_t         rsp_data;

    logic        mode_shadow;
    logic [23:0] group_acc;
    logic [1:0]  group_fill;
    int          pad_run_len;
    bit          pad_stopped;

    rsp_beat_t expected_beats[$];
    int        beats_sent = 0;
    int        mismatches = 0;
    bit        calm = 1'b0;

    base64_codec_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_data(req_data),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_data(rsp_data)
    );

    always #2ns clk = ~clk;

    function automatic logic [7:0] char8(input logic [5:0] v);
        if (v < 6'd26)
            return "A" + 8'(v);
        if (v < 6'd52)
            return "a" + 8'(v - 6'd26);
        if (v < 6'd62)
            return "0" + 8'(v - 6'd52);
        if (v == 6'd62)
            return "+";
        return "/";
    endfunction

    function automatic logic [5:0] value6(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return 6'(c - "A");
        if (c >= "a" && c <= "z")
            return 6'(c - "a" + 8'd26);
        if (c >= "0" && c <= "9")
            return 6'(c - "0" + 8'd52);
        if (c == "+")
            return 6'd62;
        if (c == "/" || c == "\\")
            return 6'd63;
        return 6'd0;
    endfunction

    function automatic void clear_group();
        group_acc = '0;
        group_fill = '0;
        pad_run_len = 0;
        pad_stopped = 1'b0;
    endfunction

    // Advances the codec state by one input beat; returns the number of result bytes.
    function automatic int codec_step(input logic [7:0] c, input logic fin,
                                      output logic [3:0][7:0] outs);
        int fill;
        int n;
        n = 0;
        outs = '0;
        fill = int'(group_fill);
        if (mode_shadow == MODE_ENCODE)
        begin
            group_acc = group_acc | ({16'd0, c} << (16 - 8 * fill));
            fill++;
            if (fill == 3 || fin)
            begin
                for (int k = 0; k < 4; k++)
                    outs[k] = (k <= fill) ? char8(6'(group_acc >> (18 - 6 * k))) : PAD_CHAR;
                n = 4;
                clear_group();
            end
            else
            begin
                group_fill = 2'(fill);
            end
        end
        else if (!pad_stopped)
        begin
            group_acc = group_acc | ({18'd0, value6(c)} << (18 - 6 * fill));
            pad_run_len = (c == PAD_CHAR) ? pad_run_len + 1 : 0;
            fill++;
            if (fill == 4)
            begin
                n = 3;
                if (c == PAD_CHAR)
                    n = (pad_run_len >= 3) ? 0 : 3 - pad_run_len;
                for (int k = 0; k < n; k++)
                    outs[k] = group_acc[23 - 8 * k -: 8];
                clear_group();
                pad_stopped = (c == PAD_CHAR);
            end
            else
            begin
                group_fill = 2'(fill);
            end
        end
        if (fin)
            clear_group();
        return n;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", what);
    endtask

    task automatic send_beat(input logic [7:0] c, input logic fin, input logic use_typed,
                             input int typed_n, input logic [31:0] typed_out);
        int gap;
        int n;
        logic [3:0][7:0] outs;
        gap = 0;
        if (!calm)
        begin
            while ($urandom_range(99) < 21)
                gap++;
        end
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= {c, fin};
        do
            @(posedge clk);
        while (req_stall);
        n = codec_step(c, fin, outs);
        if (use_typed)
        begin
            n = typed_n;
            for (int k = 0; k < 4; k++)
                outs[k] = typed_out[31 - 8 * k -: 8];
        end
        for (int k = 0; k < n; k++)
            expected_beats.push_back('{out_byte: outs[k], run_last: (k == n - 1),
                                       message_end: fin});
        beats_sent++;
    endtask

    // Waits until every expected beat is out, then lets any result-free beat finish.
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * REG_CODEC_MODE);
        pwdata <= {31'd0, m};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        mode_shadow = m;
        clear_group();
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {31'd0, mode_shadow})
            flag_mismatch($sformatf("codec_mode read: expected %h got %h",
                                    {31'd0, mode_shadow}, prdata));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [7:0] random_char();
        if ($urandom_range(19) == 0)
            return "\\";
        return char8(6'($urandom_range(63)));
    endfunction

    task automatic encode_phase(input int quota);
        int start;
        int len;
        start = beats_sent;
        while (beats_sent - start < quota)
        begin
            len = $urandom_range(1, 9);
            for (int i = 0; i < len; i++)
                send_beat(8'($urandom_range(255)), i == len - 1, 1'b0, 0, 32'd0);
        end
    endtask

    // Mostly well-formed text, with padded groups, noise groups and broken tails.
    task automatic decode_phase(input int quota);
        int start;
        int groups;
        int kind;
        int keep;
        logic [7:0] msg[$];
        start = beats_sent;
        while (beats_sent - start < quota)
        begin
            msg.delete();
            groups = $urandom_range(1, 4);
            for (int g = 0; g < groups; g++)
            begin
                kind = $urandom_range(99);
                if (kind < 70)
                begin
                    repeat (4) msg.push_back(random_char());
                end
                else if (kind < 85)
                begin
                    keep = $urandom_range(0, 3);
                    repeat (keep) msg.push_back(random_char());
                    repeat (4 - keep) msg.push_back(PAD_CHAR);
                end
                else
                begin
                    repeat (4) msg.push_back(8'($urandom_range(255)));
                end
            end
            if ($urandom_range(9) == 0)
                msg.push_back(random_char());
            if ($urandom_range(9) == 0 && msg.size() > 1)
                void'(msg.pop_back());
            foreach (msg[i])
                send_beat(msg[i], i == msg.size() - 1, 1'b0, 0, 32'd0);
        end
    endtask

    always @(posedge clk)
        rsp_stall <= !calm && ($urandom_range(99) < 21);

    always @(posedge clk)
    begin
        rsp_beat_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_beats.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected beat: out_byte %h run_last %b message_end %b",
                                        rsp_data.out_byte, rsp_data.run_last,
                                        rsp_data.message_end));
            end
            else
            begin
                want = expected_beats.pop_front();
                if (rsp_data.out_byte !== want.out_byte || rsp_data.run_last !== want.run_last
                    || rsp_data.message_end !== want.message_end)
                    flag_mismatch($sformatf({"beat mismatch: expected out_byte %h run_last %b ",
                                             "message_end %b, got %h %b %b"},
                                            want.out_byte, want.run_last, want.message_end,
                                            rsp_data.out_byte, rsp_data.run_last,
                                            rsp_data.message_end));
            end
        end
    end

    initial
    begin
        mode_shadow = MODE_ENCODE;
        clear_group();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mode(MODE_ENCODE);
        for (int r = 0; r < 25; r++)
        begin
            if (PLAN[r].mode != mode_shadow)
            begin
                settle();
                write_mode(PLAN[r].mode);
            end
            send_beat(PLAN[r].chr, PLAN[r].fin, PLAN[r].typed, PLAN[r].typed_n,
                      PLAN[r].typed_out);
        end
        for (int p = 0; p < 6; p++)
        begin
            settle();
            calm = (p == 3);
            write_mode((p % 2 == 0) ? MODE_DECODE : MODE_ENCODE);
            if (mode_shadow == MODE_ENCODE)
                encode_phase(55);
            else
                decode_phase(55);
        end
        calm = 1'b0;
        settle();
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #500us;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
